[src/bfm_pkg.sv]
// ----------------------------------------------------------------------------
// Brenner focus metric package
// Widths, reset values, register indexes and the queue status type shared by the
// front end, the job queue and the normalizer.
// ----------------------------------------------------------------------------
package bfm_pkg;

  localparam int PIX_W    = 8;
  localparam int REG_W    = 13;
  localparam int SUM_W    = 40;
  localparam int METRIC_W = 26;
  localparam int FRAC_W   = 16;
  localparam int INT_W    = METRIC_W - FRAC_W;
  localparam int SCALE_W  = 10;
  localparam int NUM_W    = SUM_W + SCALE_W;
  localparam int SQ_W     = 2 * PIX_W;

  localparam int MAX_DIMENSION_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam logic [REG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd480;

  // 255 squared, the full-scale squared difference.
  localparam logic [15:0] FULL_SCALE_SQ = 16'd65025;
  // Metric scale factor.
  localparam logic [SCALE_W-1:0] METRIC_SCALE = 10'd1000;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Queue status seen by the input stall logic and the back end.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[src/bfm_front.sv]
// ----------------------------------------------------------------------------
// Brenner focus metric front end
// Holds the frame size registers, tracks row and column, accumulates the
// squared two-apart differences and issues one job per finished frame.
// ----------------------------------------------------------------------------
module bfm_front #(
  parameter int MAX_DIMENSION = bfm_pkg::MAX_DIMENSION_DEF,
  parameter int DIM_W         = $clog2(MAX_DIMENSION + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_write_en,
  input  logic [0:0]                  cfg_index,
  input  logic [bfm_pkg::REG_W-1:0]   cfg_data,
  input  logic                        pix_accept,
  input  logic [bfm_pkg::PIX_W-1:0]   pix,
  output logic                        job_push,
  output logic [bfm_pkg::SUM_W-1:0]   job_sum,
  output logic [DIM_W-1:0]            job_width,
  output logic [DIM_W-1:0]            job_height
);

  localparam int CNT_W = $clog2(MAX_DIMENSION);
  localparam int CMP_W = DIM_W + 1;
  localparam int EXT_W = (DIM_W > bfm_pkg::REG_W) ? DIM_W : bfm_pkg::REG_W;

  logic [bfm_pkg::REG_W-1:0] width_r, width_nxt;
  logic [bfm_pkg::REG_W-1:0] height_r, height_nxt;
  logic [bfm_pkg::PIX_W-1:0] prev0_r, prev0_nxt;
  logic [bfm_pkg::PIX_W-1:0] prev1_r, prev1_nxt;
  logic [CNT_W-1:0]          col_r, col_nxt;
  logic [CNT_W-1:0]          row_r, row_nxt;
  logic [bfm_pkg::SUM_W-1:0] sum_r, sum_nxt;

  logic [DIM_W-1:0]          eff_w, eff_h;
  logic [bfm_pkg::PIX_W-1:0] diff;
  logic [bfm_pkg::SQ_W-1:0]  sq;
  logic [bfm_pkg::SUM_W:0]   sum_add;
  logic [bfm_pkg::SUM_W-1:0] sum_sat;
  logic                      col_end, row_end;

  // Clamp a register value into 1..MAX_DIMENSION.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [bfm_pkg::REG_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (EXT_W'(v) > EXT_W'(MAX_DIMENSION)) begin
      res = DIM_W'(MAX_DIMENSION);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

  always_comb begin
    eff_w   = clamp_dim(width_r);
    eff_h   = clamp_dim(height_r);
    diff    = (pix >= prev1_r) ? (pix - prev1_r) : (prev1_r - pix);
    sq      = bfm_pkg::SQ_W'(diff) * bfm_pkg::SQ_W'(diff);
    sum_add = {1'b0, sum_r} + (bfm_pkg::SUM_W + 1)'(sq);
    sum_sat = sum_add[bfm_pkg::SUM_W] ? '1 : sum_add[bfm_pkg::SUM_W-1:0];
    col_end = (CMP_W'(col_r) + CMP_W'(1)) >= CMP_W'(eff_w);
    row_end = (CMP_W'(row_r) + CMP_W'(1)) >= CMP_W'(eff_h);
  end

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    prev0_nxt  = prev0_r;
    prev1_nxt  = prev1_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    sum_nxt    = sum_r;
    job_push   = 1'b0;
    job_sum    = sum_r;
    if (cfg_write_en) begin
      unique case (bfm_pkg::cfg_reg_t'(cfg_index))
        bfm_pkg::REG_FRAME_WIDTH:  width_nxt  = cfg_data;
        bfm_pkg::REG_FRAME_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end
    if (pix_accept) begin
      if (col_r >= CNT_W'(2)) begin
        sum_nxt = sum_sat;
      end
      job_sum   = sum_nxt;
      prev1_nxt = prev0_r;
      prev0_nxt = pix;
      if (col_end) begin
        col_nxt   = '0;
        prev0_nxt = '0;
        prev1_nxt = '0;
        if (row_end) begin
          job_push = 1'b1;
          row_nxt  = '0;
          sum_nxt  = '0;
        end else begin
          row_nxt = row_r + CNT_W'(1);
        end
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  assign job_width  = eff_w;
  assign job_height = eff_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bfm_pkg::WIDTH_RESET;
      height_r <= bfm_pkg::HEIGHT_RESET;
      prev0_r  <= '0;
      prev1_r  <= '0;
      col_r    <= '0;
      row_r    <= '0;
      sum_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      prev0_r  <= prev0_nxt;
      prev1_r  <= prev1_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      sum_r    <= sum_nxt;
    end
  end

endmodule

[src/bfm_queue.sv]
// ----------------------------------------------------------------------------
// Brenner focus metric job queue
// Small first-in first-out buffer of finished-frame jobs between the pixel
// front end and the normalizer.
// ----------------------------------------------------------------------------
module bfm_queue #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = bfm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [DATA_W-1:0]     push_data,
  input  logic                  pop,
  output logic [DATA_W-1:0]     pop_data,
  output bfm_pkg::queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_data     = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[src/bfm_back.sv]
// ----------------------------------------------------------------------------
// Brenner focus metric normalizer
// Takes one job from the queue, scales the sum, divides by the frame energy
// one quotient bit per cycle or saturates, and holds the result until taken.
// ----------------------------------------------------------------------------
module bfm_back #(
  parameter int DIM_W = $clog2(bfm_pkg::MAX_DIMENSION_DEF + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bfm_pkg::queue_status_t        q_status,
  input  logic [bfm_pkg::SUM_W-1:0]     job_sum,
  input  logic [DIM_W-1:0]              job_width,
  input  logic [DIM_W-1:0]              job_height,
  output logic                          job_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bfm_pkg::SUM_W-1:0]     out_square_sum,
  output logic [bfm_pkg::METRIC_W-1:0]  out_focus_metric
);

  localparam int WH_W  = 2 * DIM_W;
  localparam int DEN_W = WH_W + 16;
  localparam int NUM_W = bfm_pkg::NUM_W;
  localparam int CMP_W = (DEN_W + bfm_pkg::INT_W > NUM_W) ? DEN_W + bfm_pkg::INT_W : NUM_W;
  localparam int MW    = bfm_pkg::METRIC_W;
  localparam int BIT_W = $clog2(MW);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_SCALE = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [bfm_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [DIM_W-1:0]          w_r, w_nxt;
  logic [DIM_W-1:0]          h_r, h_nxt;
  logic [WH_W-1:0]           wh_r, wh_nxt;
  logic [NUM_W-1:0]          num_r, num_nxt;
  logic [DEN_W-1:0]          den_r, den_nxt;
  logic [DEN_W-1:0]          rem_r, rem_nxt;
  logic [MW-1:0]             low_r, low_nxt;
  logic [MW-1:0]             quo_r, quo_nxt;
  logic [BIT_W-1:0]          bit_r, bit_nxt;

  logic [DEN_W:0]            trial;
  logic                      trial_ge;

  always_comb begin
    trial    = {rem_r, low_r[MW-1]};
    trial_ge = trial >= {1'b0, den_r};
  end

  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    w_nxt     = w_r;
    h_nxt     = h_r;
    wh_nxt    = wh_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    low_nxt   = low_r;
    quo_nxt   = quo_r;
    bit_nxt   = bit_r;
    job_pop   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          job_pop   = 1'b1;
          sum_nxt   = job_sum;
          w_nxt     = job_width;
          h_nxt     = job_height;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        wh_nxt    = WH_W'(w_r) * WH_W'(h_r);
        num_nxt   = NUM_W'(sum_r) * NUM_W'(bfm_pkg::METRIC_SCALE);
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        den_nxt   = DEN_W'(wh_r) * DEN_W'(bfm_pkg::FULL_SCALE_SQ);
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        // An integer part of 2^INT_W or more saturates the metric.
        if (CMP_W'(num_r) >= (CMP_W'(den_r) << bfm_pkg::INT_W)) begin
          quo_nxt   = '1;
          state_nxt = ST_DONE;
        end else begin
          rem_nxt   = DEN_W'(num_r >> bfm_pkg::INT_W);
          low_nxt   = {num_r[bfm_pkg::INT_W-1:0], {bfm_pkg::FRAC_W{1'b0}}};
          quo_nxt   = '0;
          bit_nxt   = BIT_W'(MW - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = trial_ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
        quo_nxt = {quo_r[MW-2:0], trial_ge};
        low_nxt = {low_r[MW-2:0], 1'b0};
        bit_nxt = bit_r - BIT_W'(1);
        if (bit_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid        = (state_r == ST_DONE);
  assign out_square_sum   = sum_r;
  assign out_focus_metric = quo_r;

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    w_r   <= w_nxt;
    h_r   <= h_nxt;
    wh_r  <= wh_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
    bit_r <= bit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/brenner_focus_metric.sv]
// ----------------------------------------------------------------------------
// Brenner focus metric
// Throughput: one pixel per cycle while in_stall is low; the frame result rate
// is set by the bit-serial divider of the normalizer (26 quotient bits).
// Reset (synchronous, rst_n low) sets the frame to 640 x 480, clears the
// counters and the sum, and empties the job queue.
// ----------------------------------------------------------------------------
//
// Pixels arrive in raster order. The front end keeps the two previous pixels
// of the current row and adds the squared difference of each pixel and the
// one two columns back into a saturating 40-bit sum. At the end of a frame it
// pushes the sum and the clamped frame size into a short job queue and starts
// the next frame at once.
//
// The back end pops a job, forms sum*1000 and 65025*width*height in its
// multiply and scale states, checks for an integer part too wide for Q10.16,
// then runs a restoring divider that yields one quotient bit per cycle. The
// result is held on the output until the downstream side takes the request.
//
// Input requests are stalled only when the job queue is full, which can happen
// only with frames shorter than the normalizer's turnaround or an output stall.
// ----------------------------------------------------------------------------
module brenner_focus_metric #(
  parameter int MAX_DIMENSION = bfm_pkg::MAX_DIMENSION_DEF,
  parameter int QUEUE_DEPTH   = bfm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write_en,
  input  logic [0:0]                    cfg_index,
  input  logic [bfm_pkg::REG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bfm_pkg::PIX_W-1:0]     in_gray_pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bfm_pkg::SUM_W-1:0]     out_square_sum,
  output logic [bfm_pkg::METRIC_W-1:0]  out_focus_metric
);

  localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int JOB_W = bfm_pkg::SUM_W + 2 * DIM_W;

  logic                      pix_accept;
  logic                      job_push;
  logic [bfm_pkg::SUM_W-1:0] front_sum;
  logic [DIM_W-1:0]          front_width, front_height;
  logic [JOB_W-1:0]          push_data, pop_data;
  logic                      job_pop;
  bfm_pkg::queue_status_t    q_status;

  // A pixel request is taken whenever the queue has room for a frame job.
  assign in_stall   = q_status.full;
  assign pix_accept = in_valid && !q_status.full;

  bfm_front #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .DIM_W         (DIM_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pix_accept   (pix_accept),
    .pix          (in_gray_pixel),
    .job_push     (job_push),
    .job_sum      (front_sum),
    .job_width    (front_width),
    .job_height   (front_height)
  );

  assign push_data = {front_sum, front_width, front_height};

  bfm_queue #(
    .DATA_W (JOB_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (push_data),
    .pop       (job_pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  bfm_back #(
    .DIM_W (DIM_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_status         (q_status),
    .job_sum          (pop_data[JOB_W-1 -: bfm_pkg::SUM_W]),
    .job_width        (pop_data[2*DIM_W-1 -: DIM_W]),
    .job_height       (pop_data[DIM_W-1:0]),
    .job_pop          (job_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_square_sum   (out_square_sum),
    .out_focus_metric (out_focus_metric)
  );

endmodule
